// ===== rtl/yfr_pkg.sv =====
// ----------------------------------------------------------------------------
// yfr_pkg
// Shared types, constants and helpers of the I420 frame rotate block.
// ----------------------------------------------------------------------------
package yfr_pkg;

   localparam int MaxWidth    = 512;
   localparam int MaxHeight   = 512;
   localparam int StoreDepth  = MaxWidth * MaxHeight * 3 / 2;
   localparam int AddrBits    = $clog2(StoreDepth);
   localparam int DimBits     = 10;
   localparam int CoordBits   = 9;
   localparam int PixBits     = 8;
   localparam int ResetWidth  = 320;
   localparam int ResetHeight = 240;
   localparam int SettleCycles = 2;

   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [DimBits-1:0]   dim_type;
   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [PixBits-1:0]   pix_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_MODE   = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic {
      MODE_TRANSPOSE = 1'b0,
      MODE_ROTATE    = 1'b1
   } rotate_mode_type;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type addr;
      pix_type  wr_data;
   } store_req_type;

   // round down to even, then saturate into 2..maxv
   function automatic dim_type clamp_dim(dim_type v, dim_type maxv);
      dim_type res;
      res = {v[DimBits-1:1], 1'b0};
      if (res > maxv) begin
         res = {maxv[DimBits-1:1], 1'b0};
      end
      if (res < dim_type'(2)) begin
         res = dim_type'(2);
      end
      return res;
   endfunction

endpackage

// ===== rtl/yfr_store.sv =====
// ----------------------------------------------------------------------------
// yfr_store
// Frame store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module yfr_store (
   input  logic                  clock,
   input  yfr_pkg::store_req_type store_req,
   output yfr_pkg::pix_type      rd_data
);
   import yfr_pkg::*;

   pix_type mem [StoreDepth];
   pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/yuv420_frame_rotate.sv =====
// ----------------------------------------------------------------------------
// yuv420_frame_rotate
// Loads one planar I420 frame into a frame store and reads it back
// transposed or rotated ninety degrees, plane by plane.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tuser          | tlast
//  req     | in        | pixel_in       | req_type       | -
//  rsp     | out       | pixel_out      | status         | last_byte
//  csr     | in        | index, wdata   | -              | -
//
//  One item per cycle while req is not stalled; a read result appears in
//  the cycle after its request, from the registered read port of the frame
//  store. Loads produce no result. The result register frees as it is
//  taken, so req stalls only while settling or while rsp_tready low holds
//  a result. After reset and after each csr write, req is held off by a
//  settle counter while the plane size product and plane bases settle.
//  Reset is synchronous; the frame store itself is not cleared.
// ----------------------------------------------------------------------------
module yuv420_frame_rotate (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  yfr_pkg::pix_type      req_tdata,   // [7:0] pixel_in
   input  logic                  req_tuser,   // [0] req_type
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output yfr_pkg::pix_type      rsp_tdata,   // [7:0] pixel_out
   output logic                  rsp_tuser,   // [0] status
   output logic                  rsp_tlast,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  yfr_pkg::dim_type      csr_wdata
);
   import yfr_pkg::*;

   // configuration, stored already clamped
   dim_type   eff_w_ff, eff_w_in;
   dim_type   eff_h_ff, eff_h_in;
   logic      mode_ff, mode_in;
   logic      restart;
   logic [1:0] settle_ff, settle_in;

   // derived sizes
   addr_type  luma_ff, total_ff, v_base_ff;

   // frame counters
   addr_type  load_pos_ff, load_pos_in;
   logic      loaded_ff, loaded_in;
   coord_type out_row_ff, out_row_in;
   coord_type out_col_ff, out_col_in;
   plane_type plane_ff, plane_in;
   addr_type  row_base_ff, row_base_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_status_ff, rsp_status_in;
   logic      rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          cfg_wr;
   logic          is_read;
   dim_type       pw, ph;
   coord_type     col;
   addr_type      rd_addr;
   addr_type      load_next;
   logic          row_end, col_end, last;
   plane_type     plane_next;
   store_req_type store_req;
   pix_type       rd_data;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;
   assign req_tready = (settle_ff == 2'd0) && (!rsp_valid_ff || rsp_tready);
   assign accept    = req_tvalid && req_tready;
   assign is_read   = (req_kind_type'(req_tuser) == REQ_READ);

   // ---------------- configuration ----------------
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      mode_in  = mode_ff;
      restart  = 1'b0;
      if (cfg_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH: begin
               eff_w_in = clamp_dim(csr_wdata, dim_type'(MaxWidth));
               restart  = 1'b1;
            end
            CSR_HEIGHT: begin
               eff_h_in = clamp_dim(csr_wdata, dim_type'(MaxHeight));
               restart  = 1'b1;
            end
            CSR_MODE: begin
               mode_in = csr_wdata[0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (cfg_wr) begin
         settle_in = 2'(SettleCycles);
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff  <= dim_type'(ResetWidth);
         eff_h_ff  <= dim_type'(ResetHeight);
         mode_ff   <= MODE_TRANSPOSE;
         settle_ff <= 2'(SettleCycles);
      end else begin
         eff_w_ff  <= eff_w_in;
         eff_h_ff  <= eff_h_in;
         mode_ff   <= mode_in;
         settle_ff <= settle_in;
      end
   end

   // luma size, frame size and V plane base
   always_ff @(posedge clock) begin
      luma_ff   <= addr_type'(eff_w_ff) * addr_type'(eff_h_ff);
      total_ff  <= luma_ff + (luma_ff >> 1);
      v_base_ff <= luma_ff + (luma_ff >> 2);
   end

   // ---------------- address generation ----------------
   always_comb begin
      if (plane_ff == PLANE_Y) begin
         pw = eff_w_ff;
         ph = eff_h_ff;
      end else begin
         pw = eff_w_ff >> 1;
         ph = eff_h_ff >> 1;
      end
      if (rotate_mode_type'(mode_ff) == MODE_ROTATE) begin
         col = coord_type'(pw - dim_type'(1) - dim_type'(out_col_ff));
      end else begin
         col = out_col_ff;
      end
      rd_addr   = row_base_ff + addr_type'(col);
      row_end   = (dim_type'(out_row_ff) + dim_type'(1)) >= ph;
      col_end   = (dim_type'(out_col_ff) + dim_type'(1)) >= pw;
      last      = (plane_ff == PLANE_V) && row_end && col_end;
      load_next = load_pos_ff + addr_type'(1);
      plane_next = col_end ? plane_type'(plane_ff + 2'd1) : plane_ff;
   end

   always_comb begin
      load_pos_in = load_pos_ff;
      loaded_in   = loaded_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      plane_in    = plane_ff;
      row_base_in = row_base_ff;
      if (restart) begin
         load_pos_in = '0;
         loaded_in   = 1'b0;
         out_row_in  = '0;
         out_col_in  = '0;
         plane_in    = PLANE_Y;
         row_base_in = '0;
      end else if (accept) begin
         if (!is_read) begin
            if (!loaded_ff) begin
               load_pos_in = load_next;
               if (load_next >= total_ff) begin
                  loaded_in = 1'b1;
               end
            end
         end else if (loaded_ff) begin
            if (last) begin
               // frame released, next load starts a new one
               load_pos_in = '0;
               loaded_in   = 1'b0;
               out_row_in  = '0;
               out_col_in  = '0;
               plane_in    = PLANE_Y;
               row_base_in = '0;
            end else if (row_end) begin
               out_row_in = '0;
               plane_in   = plane_next;
               out_col_in = col_end ? '0 : coord_type'(out_col_ff + coord_type'(1));
               case (plane_next)
                  PLANE_Y: row_base_in = '0;
                  PLANE_U: row_base_in = luma_ff;
                  default: row_base_in = v_base_ff;
               endcase
            end else begin
               out_row_in  = out_row_ff + coord_type'(1);
               row_base_in = row_base_ff + addr_type'(pw);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         loaded_ff   <= 1'b0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         plane_ff    <= PLANE_Y;
         row_base_ff <= '0;
      end else begin
         load_pos_ff <= load_pos_in;
         loaded_ff   <= loaded_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         plane_ff    <= plane_in;
         row_base_ff <= row_base_in;
      end
   end

   // ---------------- frame store ----------------
   always_comb begin
      store_req.wr_en   = accept && !is_read && !loaded_ff;
      store_req.rd_en   = accept && is_read && loaded_ff;
      store_req.addr    = store_req.wr_en ? load_pos_ff : rd_addr;
      store_req.wr_data = req_tdata;
   end

   yfr_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (accept && is_read) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = !loaded_ff;
         rsp_last_in   = loaded_ff && last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   // not-ready results carry a zero byte
   assign rsp_tdata  = rsp_status_ff ? '0 : rd_data;

endmodule
